[sv/ffrc_pkg.sv]
// ----------------------------------------------------------------------------
// ffrc_pkg
// Types and constants shared by the frame receive checker modules.
// ----------------------------------------------------------------------------
package ffrc_pkg;

	localparam int FRAME_BYTES = 13;
	localparam int POS_W       = 4;

	// frame positions
	localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LEN  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_ID   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_PAY0 = POS_W'(3);
	localparam logic [POS_W-1:0] POS_PAYN = POS_W'(10);
	localparam logic [POS_W-1:0] POS_SUM  = POS_W'(11);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	// frame status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADEND = 2'd1;
	localparam logic [1:0] ST_BADSUM = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'd1;

	localparam logic [7:0] START_BYTE_RST = 8'd2;
	localparam logic [7:0] END_BYTE_RST   = 8'd3;

	// what the back end does with a queued byte
	typedef enum logic [1:0] {
		KIND_ID,
		KIND_PAY,
		KIND_SUM,
		KIND_END
	} byte_kind_t;

	typedef struct packed {
		byte_kind_t kind;
		logic [7:0] data;
	} q_entry_t;

endpackage

[sv/ffrc_in_if.sv]
// ----------------------------------------------------------------------------
// ffrc_in_if
// Received byte channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface ffrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/ffrc_out_if.sv]
// ----------------------------------------------------------------------------
// ffrc_out_if
// Frame result channel: status, ID and payload of one checked frame.
// ----------------------------------------------------------------------------
interface ffrc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [7:0]  frame_id;
	logic [63:0] payload;

	modport source (output valid, output frame_status, output frame_id,
		output payload, input ready);
	modport sink   (input valid, input frame_status, input frame_id,
		input payload, output ready);
endinterface

[sv/fixed_frame_receive_checker_top.sv]
// Each end byte passes through the byte queue before its result is registered,
// and it is held back while an earlier result still waits on the output.
// Throughput: one byte per cycle; the back end retires one queued byte per cycle.
// A full queue (QUEUE_DEPTH entries) or a stalled result holds off input.
// Reset: asynchronous, active low; clears position, queue and result valid,
// and sets the start byte to 2 and the end byte to 3.
// ----------------------------------------------------------------------------
// fixed_frame_receive_checker_top
// Checks fixed 13-byte start/end framed messages with an additive checksum.
// ----------------------------------------------------------------------------
module fixed_frame_receive_checker_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ffrc_in_if.sink                        in_ch,
	ffrc_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [ffrc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                     cfg_data
);
	import ffrc_pkg::*;

	logic [7:0] start_byte_q;
	logic [7:0] end_byte_q;

	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_not_empty;
	q_entry_t push_entry;
	q_entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_START: start_byte_q <= cfg_data;
				CFG_END:   end_byte_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	ffrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.start_byte (start_byte_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ffrc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	ffrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.end_byte    (end_byte_q),
		.out_ch      (out_ch)
	);

endmodule

[sv/ffrc_front.sv]
// ----------------------------------------------------------------------------
// ffrc_front
// Hunts for the start byte, tracks frame position and tags frame bytes.
// ----------------------------------------------------------------------------
module ffrc_front (
	input  logic              clk,
	input  logic              arst_n,
	ffrc_in_if.sink           in_ch,
	input  logic [7:0]        start_byte,
	input  logic              q_full,
	output logic              push,
	output ffrc_pkg::q_entry_t push_entry
);
	import ffrc_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             accept;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;

	// hunt and length bytes are consumed here and never queued
	assign push = accept && (pos_q >= POS_ID);

	always_comb begin
		push_entry.data = in_ch.rx_byte;
		priority if (pos_q == POS_ID) begin
			push_entry.kind = KIND_ID;
		end else if (pos_q <= POS_PAYN) begin
			push_entry.kind = KIND_PAY;
		end else if (pos_q == POS_SUM) begin
			push_entry.kind = KIND_SUM;
		end else begin
			push_entry.kind = KIND_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (accept) begin
			priority if (pos_q == POS_HUNT) begin
				if (in_ch.rx_byte == start_byte) begin
					pos_q <= POS_LEN;
				end
			end else if (pos_q >= POS_LAST) begin
				pos_q <= POS_HUNT;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

[sv/ffrc_fifo.sv]
// ----------------------------------------------------------------------------
// ffrc_fifo
// Short queue of tagged frame bytes between front and back end.
// ----------------------------------------------------------------------------
module ffrc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ffrc_pkg::q_entry_t push_entry,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output ffrc_pkg::q_entry_t head
);
	import ffrc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/ffrc_back.sv]
// ----------------------------------------------------------------------------
// ffrc_back
// Accumulates checksum, ID and payload and registers the frame result.
// ----------------------------------------------------------------------------
module ffrc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  ffrc_pkg::q_entry_t head,
	output logic               pop,
	input  logic [7:0]         end_byte,
	ffrc_out_if.source         out_ch
);
	import ffrc_pkg::*;

	logic [7:0]  sum_q;
	logic [7:0]  id_q;
	logic [63:0] pay_q;
	logic [7:0]  rx_sum_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [7:0]  out_id_q;
	logic [63:0] out_pay_q;

	logic        out_free;
	logic [1:0]  status;

	assign out_free = !out_valid_q || out_ch.ready;
	// only the end byte needs room in the output register
	assign pop = q_not_empty && ((head.kind != KIND_END) || out_free);

	always_comb begin
		priority if (head.data != end_byte) begin
			status = ST_BADEND;
		end else if (rx_sum_q != sum_q) begin
			status = ST_BADSUM;
		end else begin
			status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (head.kind)
				KIND_ID: begin
					sum_q <= head.data;
					id_q  <= head.data;
				end
				KIND_PAY: begin
					sum_q <= sum_q + head.data;
					pay_q <= {head.data, pay_q[63:8]};
				end
				KIND_SUM: begin
					rx_sum_q <= head.data;
				end
				KIND_END: begin
					out_status_q <= status;
					out_id_q     <= id_q;
					out_pay_q    <= pay_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && (head.kind == KIND_END)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.frame_status = out_status_q;
	assign out_ch.frame_id     = out_id_q;
	assign out_ch.payload      = out_pay_q;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-frame receive checker. Byte streams built
// from framed messages (good, bad end, bad checksum, both, cut short) plus
// noise go in under random burst/gap timing. A cycle-level tracker of the
// frame position and checksum predicts each result, and every result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import ffrc_pkg::*;

	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_HOLD    = 200;
	localparam int QUIET_LIMIT  = 5000;
	localparam int BYTE_TARGET  = 1700;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  id;
		logic [63:0] payload;
	} frame_result_t;

	typedef enum logic [1:0] {
		FLAW_NONE,
		FLAW_END,
		FLAW_SUM,
		FLAW_BOTH
	} frame_flaw_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [7:0]           cfg_data;

	ffrc_in_if  byte_ch ();
	ffrc_out_if frame_ch ();

	fixed_frame_receive_checker_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (byte_ch),
		.out_ch   (frame_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// framing bytes currently programmed
	logic [7:0] cur_start = START_BYTE_RST;
	logic [7:0] cur_end   = END_BYTE_RST;

	logic [7:0]    rx_bytes_pending[$];
	frame_result_t frame_results_due[$];
	int            bytes_queued = 0;
	int            err_cnt = 0;
	int            long_hold_req = 0;

	// receive-side tracker state
	logic [POS_W-1:0] trk_pos;
	logic [7:0]       trk_sum;
	logic [7:0]       trk_id;
	logic [63:0]      trk_payload;
	logic [7:0]       trk_rx_sum;

	function automatic void track_rx_byte(input logic [7:0] b);
		frame_result_t res;
		if (trk_pos == POS_HUNT) begin
			if (b == cur_start) begin
				trk_pos     = POS_LEN;
				trk_sum     = '0;
				trk_id      = '0;
				trk_payload = '0;
				trk_rx_sum  = '0;
			end
		end else if (trk_pos == POS_LEN) begin
			trk_pos = POS_ID;
		end else if (trk_pos == POS_ID) begin
			trk_id  = b;
			trk_sum = trk_sum + b;
			trk_pos = POS_PAY0;
		end else if (trk_pos >= POS_PAY0 && trk_pos <= POS_PAYN) begin
			trk_payload = {b, trk_payload[63:8]};
			trk_sum     = trk_sum + b;
			trk_pos     = trk_pos + 1'b1;
		end else if (trk_pos == POS_SUM) begin
			trk_rx_sum = b;
			trk_pos    = trk_pos + 1'b1;
		end else begin
			// end byte is checked ahead of the checksum
			if (b != cur_end)
				res.status = ST_BADEND;
			else if (trk_rx_sum != trk_sum)
				res.status = ST_BADSUM;
			else
				res.status = ST_OK;
			res.id      = trk_id;
			res.payload = trk_payload;
			frame_results_due.push_back(res);
			trk_pos = POS_HUNT;
		end
	endfunction

	// byte sender: bursts of random length separated by random gaps
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid   <= 1'b0;
			byte_ch.rx_byte <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!(byte_ch.valid && !byte_ch.ready)) begin
			if (gap_left != 0) begin
				gap_left--;
				byte_ch.valid <= 1'b0;
			end else if (rx_bytes_pending.size() != 0) begin
				byte_ch.valid   <= 1'b1;
				byte_ch.rx_byte <= rx_bytes_pending.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 64);
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
				end else begin
					burst_left--;
				end
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: changing stall modes, plus a long hold-off on request
	rx_mode_t rx_mode;
	int       rx_mode_left;
	int       hold_left;
	int       hold_seen;
	logic     toggle_bit;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
			rx_mode      = RX_OPEN;
			rx_mode_left = 0;
			hold_left    = 0;
			hold_seen    = 0;
			toggle_bit   = 1'b0;
		end else begin
			if (hold_seen != long_hold_req) begin
				hold_seen = long_hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				frame_ch.ready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode      = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(10, 120);
				end else begin
					rx_mode_left--;
				end
				toggle_bit = ~toggle_bit;
				case (rx_mode)
					RX_OPEN:   frame_ch.ready <= 1'b1;
					RX_MOSTLY: frame_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: frame_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   frame_ch.ready <= toggle_bit;
				endcase
			end
		end
	end

	// prediction on input transactions, checking on result transactions
	int            quiet_cycles;
	frame_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_pos      = POS_HUNT;
			trk_sum      = '0;
			trk_id       = '0;
			trk_payload  = '0;
			trk_rx_sum   = '0;
			quiet_cycles = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				track_rx_byte(byte_ch.rx_byte);
			if (frame_ch.valid && frame_ch.ready) begin
				if (frame_results_due.size() == 0) begin
					$display("%0t: result with none expected: status %0d id %02h payload %016h",
						$time, frame_ch.frame_status, frame_ch.frame_id, frame_ch.payload);
					err_cnt++;
				end else begin
					want = frame_results_due.pop_front();
					if (frame_ch.frame_status !== want.status) begin
						$display("%0t: frame_status expected %0d actual %0d",
							$time, want.status, frame_ch.frame_status);
						err_cnt++;
					end
					if (frame_ch.frame_id !== want.id) begin
						$display("%0t: frame_id expected %02h actual %02h",
							$time, want.id, frame_ch.frame_id);
						err_cnt++;
					end
					if (frame_ch.payload !== want.payload) begin
						$display("%0t: payload expected %016h actual %016h",
							$time, want.payload, frame_ch.payload);
						err_cnt++;
					end
				end
			end
			if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic void push_byte(input logic [7:0] b);
		rx_bytes_pending.push_back(b);
		bytes_queued++;
	endfunction

	function automatic void queue_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			if (b == cur_start)
				b = b ^ 8'h01;
			push_byte(b);
		end
	endfunction

	function automatic void queue_frame(input logic [7:0] fid, input logic [63:0] pay,
		input frame_flaw_t flaw);
		logic [7:0] csum;
		logic [7:0] tail;
		csum = fid;
		push_byte(cur_start);
		push_byte(8'($urandom));
		push_byte(fid);
		for (int i = 0; i < 8; i++) begin
			csum = csum + pay[8*i +: 8];
			push_byte(pay[8*i +: 8]);
		end
		if (flaw == FLAW_SUM || flaw == FLAW_BOTH)
			csum = csum + 8'($urandom_range(1, 255));
		tail = cur_end;
		if (flaw == FLAW_END || flaw == FLAW_BOTH)
			tail = tail ^ 8'($urandom_range(1, 255));
		push_byte(csum);
		push_byte(tail);
	endfunction

	function automatic void queue_random_frame();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			// cut short: a start byte and at most 11 noise bytes, so a following start byte can land inside this frame
			push_byte(cur_start);
			queue_noise($urandom_range(1, 11));
		end else begin
			queue_frame(8'($urandom), {$urandom, $urandom},
				(pick < 75) ? FLAW_NONE : (pick < 85) ? FLAW_END :
				(pick < 95) ? FLAW_SUM : FLAW_BOTH);
		end
		if ($urandom_range(0, 3) == 0)
			queue_noise($urandom_range(1, 4));
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (rx_bytes_pending.size() != 0 || byte_ch.valid || frame_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START)
			cur_start = val;
		else
			cur_end = val;
	endtask

	task automatic set_framing(input logic [7:0] sb, input logic [7:0] eb);
		write_reg(CFG_START, sb);
		write_reg(CFG_END, eb);
	endtask

	function automatic logic [7:0] pick_reg_value();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		cfg_we           = 1'b0;
		cfg_idx          = CFG_START;
		cfg_data         = '0;
		byte_ch.valid    = 1'b0;
		byte_ch.rx_byte  = '0;
		frame_ch.ready   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset framing bytes
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(END_BYTE_RST);
		queue_frame(8'hFF, '1, FLAW_NONE);
		queue_frame(8'h00, '0, FLAW_NONE);
		queue_frame(8'($urandom), {$urandom, $urandom}, FLAW_END);
		queue_frame(8'($urandom), {$urandom, $urandom}, FLAW_SUM);
		queue_frame(8'($urandom), {$urandom, $urandom}, FLAW_BOTH);
		queue_frame(cur_start, {8{cur_start}}, FLAW_NONE);
		wait_idle();

		// leave a frame open across a framing change
		set_framing(8'h00, 8'hFF);
		repeat (15) queue_random_frame();
		push_byte(cur_start);
		queue_noise(6);
		wait_idle();
		set_framing(8'hFF, 8'h00);
		for (int i = 0; i < 5; i++)
			push_byte(8'($urandom));
		push_byte(cur_end);
		repeat (15) queue_random_frame();
		wait_idle();

		// result side held off while bytes keep coming
		set_framing(8'($urandom), 8'($urandom));
		long_hold_req++;
		repeat (30) queue_random_frame();
		wait_idle();

		// start and end share one value
		set_framing(8'h7E, 8'h7E);
		repeat (15) queue_random_frame();
		wait_idle();

		while (bytes_queued < BYTE_TARGET) begin
			set_framing(pick_reg_value(), pick_reg_value());
			repeat ($urandom_range(10, 25)) queue_random_frame();
			wait_idle();
		end

		if (err_cnt == 0 && frame_results_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
